/* src/obb_pkg.sv */
`default_nettype none

package obb_pkg;

   localparam int ANGLE_BITS = 12;
   localparam int COORD_BITS = 16;

   localparam int QUAD_BITS = ANGLE_BITS - 2;
   localparam int T_W       = 17;
   localparam int P_W       = 32;
   localparam int SIN_W     = 16;
   localparam int RX_W      = 17;
   localparam int MX_W      = COORD_BITS + RX_W;
   localparam int X_W       = COORD_BITS + RX_W + 1;
   localparam int N_W       = COORD_BITS + 17;
   localparam int XL        = 17;
   localparam int XH        = X_W - XL;
   localparam int PH_W      = XH + N_W;
   localparam int PL_W      = XL + 1 + N_W;
   localparam int D_W       = X_W + N_W + 2;

   localparam int SINE_LAT = 7;
   localparam int LANE_LAT = 5;
   localparam int PIPE_LAT = SINE_LAT + 1 + LANE_LAT;

   localparam logic [T_W-1:0] TURN_Q16 = T_W'(65536);
   localparam logic signed [P_W-1:0] SINE_ONE = P_W'(16384);
   localparam logic signed [P_W-1:0] SINE_HALF_LSB = P_W'(8192);

   localparam logic signed [P_W-1:0] COEF_A1 = P_W'(421657428);
   localparam logic signed [P_W-1:0] COEF_A3 = -P_W'(173398217);
   localparam logic signed [P_W-1:0] COEF_A5 = P_W'(21392299);
   localparam logic signed [P_W-1:0] COEF_A7 = -P_W'(1256749);
   localparam logic signed [P_W-1:0] COEF_A9 = P_W'(43068);

   typedef logic [ANGLE_BITS-1:0]     angle_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SIN_W-1:0]   sin_type;
   typedef logic signed [X_W-1:0]     pos_type;
   typedef logic signed [N_W-1:0]     norm_type;
   typedef logic signed [D_W-1:0]     proj_type;

   typedef struct packed {
      coord_type a_pos_x;
      coord_type a_pos_y;
      coord_type a_scale_x;
      coord_type a_scale_y;
      angle_type a_angle;
      coord_type b_pos_x;
      coord_type b_pos_y;
      coord_type b_scale_x;
      coord_type b_scale_y;
      angle_type b_angle;
   } req_word_type;

   typedef struct packed {
      logic collided;
   } rsp_word_type;

endpackage

`default_nettype wire

/* src/obb_req_if.sv */
`default_nettype none

interface obb_req_if;
   logic                 valid;
   logic                 ready;
   obb_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/obb_rsp_if.sv */
`default_nettype none

interface obb_rsp_if;
   logic                 valid;
   logic                 ready;
   obb_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/obb_sine.sv */
`default_nettype none

module obb_sine (
   input  logic               clock,
   input  logic               en,
   input  obb_pkg::angle_type angle,
   output obb_pkg::sin_type   value_ff
);

   logic [1:0]                   q_in;
   logic [obb_pkg::QUAD_BITS-1:0] r_in;
   logic [obb_pkg::T_W-1:0]      t_raw;
   logic [obb_pkg::T_W-1:0]      t_in;
   logic [2*obb_pkg::T_W-1:0]    tt;

   logic [obb_pkg::T_W-1:0]      t2_ff [1:4];
   logic [obb_pkg::T_W-1:0]      t_ff [1:5];
   logic [1:0]                   q_ff [1:6];
   logic signed [obb_pkg::P_W-1:0] p_ff [1:6];

   logic signed [obb_pkg::P_W-1:0] coef [2:5];
   logic signed [obb_pkg::P_W+obb_pkg::T_W:0] prod [2:6];
   logic signed [obb_pkg::P_W-1:0] p_in [2:6];
   logic signed [obb_pkg::P_W-1:0] v;
   obb_pkg::sin_type               mag;
   obb_pkg::sin_type               value_in;

   assign coef[2] = obb_pkg::COEF_A7;
   assign coef[3] = obb_pkg::COEF_A5;
   assign coef[4] = obb_pkg::COEF_A3;
   assign coef[5] = obb_pkg::COEF_A1;

   always_comb begin
      q_in  = angle[obb_pkg::ANGLE_BITS-1 -: 2];
      r_in  = angle[obb_pkg::QUAD_BITS-1:0];
      t_raw = obb_pkg::T_W'(r_in) << (16 - obb_pkg::QUAD_BITS);
      t_in  = q_in[0] ? (obb_pkg::TURN_Q16 - t_raw) : t_raw;
      tt    = t_in * t_in;
      for (int k = 2; k <= 5; k++) begin
         prod[k] = p_ff[k-1] * $signed({1'b0, t2_ff[k-1]});
         p_in[k] = coef[k] + obb_pkg::P_W'(prod[k] >>> 16);
      end
      prod[6] = p_ff[5] * $signed({1'b0, t_ff[5]});
      p_in[6] = obb_pkg::P_W'(prod[6] >>> 16);
      v = (p_ff[6] + obb_pkg::SINE_HALF_LSB) >>> 14;
      if (v < 0) begin
         mag = '0;
      end else if (v > obb_pkg::SINE_ONE) begin
         mag = obb_pkg::SIN_W'(obb_pkg::SINE_ONE);
      end else begin
         mag = obb_pkg::SIN_W'(v);
      end
      value_in = q_ff[6][1] ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_ff[1] <= tt[obb_pkg::T_W+15:16];
         t_ff[1]  <= t_in;
         q_ff[1]  <= q_in;
         p_ff[1]  <= obb_pkg::COEF_A9;
         for (int k = 2; k <= 4; k++) begin
            t2_ff[k] <= t2_ff[k-1];
         end
         for (int k = 2; k <= 5; k++) begin
            t_ff[k] <= t_ff[k-1];
         end
         for (int k = 2; k <= 6; k++) begin
            q_ff[k] <= q_ff[k-1];
            p_ff[k] <= p_in[k];
         end
         value_ff <= value_in;
      end
   end

endmodule

`default_nettype wire

/* src/obb_box_geom.sv */
`default_nettype none

module obb_box_geom (
   input  logic               clock,
   input  logic               en,
   input  obb_pkg::sin_type   s,
   input  obb_pkg::sin_type   c,
   input  obb_pkg::coord_type pos_x,
   input  obb_pkg::coord_type pos_y,
   input  obb_pkg::coord_type scale_x,
   input  obb_pkg::coord_type scale_y,
   output obb_pkg::pos_type   x_ff [4],
   output obb_pkg::pos_type   y_ff [4],
   output obb_pkg::norm_type  ex_ff [4],
   output obb_pkg::norm_type  ey_ff [4]
);

   logic signed [obb_pkg::RX_W-1:0] s_ext, c_ext;
   logic signed [obb_pkg::RX_W-1:0] rx [4], ry [4], dx [4], dy [4];
   logic signed [obb_pkg::MX_W-1:0] mx [4], my [4];
   obb_pkg::pos_type                x_in [4], y_in [4];
   obb_pkg::norm_type               ex_in [4], ey_in [4];

   always_comb begin
      s_ext = obb_pkg::RX_W'(s);
      c_ext = obb_pkg::RX_W'(c);
      rx[0] = '0;             ry[0] = '0;
      rx[1] = -s_ext;         ry[1] = c_ext;
      rx[2] = c_ext - s_ext;  ry[2] = s_ext + c_ext;
      rx[3] = c_ext;          ry[3] = s_ext;
      dx[0] = -s_ext;         dy[0] = c_ext;
      dx[1] = c_ext;          dy[1] = s_ext;
      dx[2] = s_ext;          dy[2] = -c_ext;
      dx[3] = -c_ext;         dy[3] = -s_ext;
      for (int k = 0; k < 4; k++) begin
         mx[k]    = scale_x * rx[k];
         my[k]    = scale_y * ry[k];
         x_in[k]  = obb_pkg::X_W'(mx[k]) + (obb_pkg::X_W'(pos_x) <<< 14);
         y_in[k]  = obb_pkg::X_W'(my[k]) + (obb_pkg::X_W'(pos_y) <<< 14);
         ex_in[k] = scale_x * dx[k];
         ey_in[k] = scale_y * dy[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         ex_ff <= ex_in;
         ey_ff <= ey_in;
      end
   end

endmodule

`default_nettype wire

/* src/obb_axis_lane.sv */
`default_nettype none

module obb_axis_lane (
   input  logic              clock,
   input  logic              en,
   input  obb_pkg::pos_type  xa [4],
   input  obb_pkg::pos_type  ya [4],
   input  obb_pkg::pos_type  xb [4],
   input  obb_pkg::pos_type  yb [4],
   input  obb_pkg::norm_type ex,
   input  obb_pkg::norm_type ey,
   output logic              ok_ff
);

   obb_pkg::pos_type                 cx [8], cy [8];
   obb_pkg::norm_type                nx, ny;
   logic signed [obb_pkg::XH-1:0]    hx [8], hy [8];
   logic signed [obb_pkg::XL:0]      lx [8], ly [8];
   logic signed [obb_pkg::PH_W-1:0]  phx_in [8], phy_in [8];
   logic signed [obb_pkg::PL_W-1:0]  plx_in [8], ply_in [8];
   logic signed [obb_pkg::PH_W-1:0]  phx_ff [8], phy_ff [8];
   logic signed [obb_pkg::PL_W-1:0]  plx_ff [8], ply_ff [8];
   obb_pkg::proj_type                d_in [8], d_ff [8];
   obb_pkg::proj_type                mn_in [4], mx_in [4], mn_ff [4], mx_ff [4];
   obb_pkg::proj_type                lo_in [2], hi_in [2], lo_ff [2], hi_ff [2];
   logic                             zero_ff [1:4];
   logic                             ok_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cx[k]   = xa[k];
         cy[k]   = ya[k];
         cx[k+4] = xb[k];
         cy[k+4] = yb[k];
      end
      nx = -ey;
      ny = ex;
      for (int j = 0; j < 8; j++) begin
         hx[j]     = cx[j][obb_pkg::X_W-1:obb_pkg::XL];
         hy[j]     = cy[j][obb_pkg::X_W-1:obb_pkg::XL];
         lx[j]     = $signed({1'b0, cx[j][obb_pkg::XL-1:0]});
         ly[j]     = $signed({1'b0, cy[j][obb_pkg::XL-1:0]});
         phx_in[j] = hx[j] * nx;
         phy_in[j] = hy[j] * ny;
         plx_in[j] = lx[j] * nx;
         ply_in[j] = ly[j] * ny;
         d_in[j]   = (obb_pkg::D_W'(phx_ff[j]) <<< obb_pkg::XL) + obb_pkg::D_W'(plx_ff[j])
                   + (obb_pkg::D_W'(phy_ff[j]) <<< obb_pkg::XL) + obb_pkg::D_W'(ply_ff[j]);
      end
      for (int p = 0; p < 4; p++) begin
         mn_in[p] = (d_ff[2*p+1] < d_ff[2*p]) ? d_ff[2*p+1] : d_ff[2*p];
         mx_in[p] = (d_ff[2*p] < d_ff[2*p+1]) ? d_ff[2*p+1] : d_ff[2*p];
      end
      for (int b = 0; b < 2; b++) begin
         lo_in[b] = (mn_ff[2*b+1] < mn_ff[2*b]) ? mn_ff[2*b+1] : mn_ff[2*b];
         hi_in[b] = (mx_ff[2*b] < mx_ff[2*b+1]) ? mx_ff[2*b+1] : mx_ff[2*b];
      end
      ok_in = !zero_ff[4] && !(hi_ff[1] < lo_ff[0]) && !(hi_ff[0] < lo_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phx_ff     <= phx_in;
         phy_ff     <= phy_in;
         plx_ff     <= plx_in;
         ply_ff     <= ply_in;
         zero_ff[1] <= (ex == '0) && (ey == '0);
         for (int k = 2; k <= 4; k++) begin
            zero_ff[k] <= zero_ff[k-1];
         end
         d_ff  <= d_in;
         mn_ff <= mn_in;
         mx_ff <= mx_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         ok_ff <= ok_in;
      end
   end

endmodule

`default_nettype wire

/* src/obb_sat_overlap_test.sv */
`default_nettype none

// Channel  Port    Direction  Word
// request  req_ch  in         two boxes: position, scale, angle of each
// result   rsp_ch  out        collided flag
//
// Each word passes from acceptance through the sine and cosine pipelines, the corner
// and edge registers, the eight axis lanes and the result register. One word is
// accepted every cycle while the result register is empty or being taken.
// Reset is synchronous and clears only the valid flags of the pipeline.
// The whole pipeline holds while the result register is full and not taken.

module obb_sat_overlap_test (
   input logic        clock,
   input logic        reset,
   obb_req_if.sink    req_ch,
   obb_rsp_if.source  rsp_ch
);

   logic                   en;
   logic                   valid_ff [1:obb_pkg::PIPE_LAT];
   obb_pkg::req_word_type  fld_ff [1:obb_pkg::SINE_LAT];
   logic                   rsp_valid_ff;
   logic                   collided_ff;
   obb_pkg::angle_type     quarter;
   obb_pkg::sin_type       sa, ca, sb, cb;
   obb_pkg::pos_type       xa [4], ya [4], xb [4], yb [4];
   obb_pkg::norm_type      exa [4], eya [4], exb [4], eyb [4];
   logic [7:0]             lane_ok;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data.collided = collided_ff;
   assign quarter = obb_pkg::ANGLE_BITS'(1) << (obb_pkg::ANGLE_BITS - 2);

   obb_sine u_sin_a (.clock(clock), .en(en), .angle(req_ch.data.a_angle), .value_ff(sa));
   obb_sine u_cos_a (.clock(clock), .en(en), .angle(req_ch.data.a_angle + quarter),
                     .value_ff(ca));
   obb_sine u_sin_b (.clock(clock), .en(en), .angle(req_ch.data.b_angle), .value_ff(sb));
   obb_sine u_cos_b (.clock(clock), .en(en), .angle(req_ch.data.b_angle + quarter),
                     .value_ff(cb));

   obb_box_geom u_geom_a (
      .clock(clock), .en(en), .s(sa), .c(ca),
      .pos_x(fld_ff[obb_pkg::SINE_LAT].a_pos_x), .pos_y(fld_ff[obb_pkg::SINE_LAT].a_pos_y),
      .scale_x(fld_ff[obb_pkg::SINE_LAT].a_scale_x),
      .scale_y(fld_ff[obb_pkg::SINE_LAT].a_scale_y),
      .x_ff(xa), .y_ff(ya), .ex_ff(exa), .ey_ff(eya)
   );

   obb_box_geom u_geom_b (
      .clock(clock), .en(en), .s(sb), .c(cb),
      .pos_x(fld_ff[obb_pkg::SINE_LAT].b_pos_x), .pos_y(fld_ff[obb_pkg::SINE_LAT].b_pos_y),
      .scale_x(fld_ff[obb_pkg::SINE_LAT].b_scale_x),
      .scale_y(fld_ff[obb_pkg::SINE_LAT].b_scale_y),
      .x_ff(xb), .y_ff(yb), .ex_ff(exb), .ey_ff(eyb)
   );

   for (genvar l = 0; l < 8; l++) begin : g_lane
      if (l < 4) begin : g_box_a
         obb_axis_lane u_lane (
            .clock(clock), .en(en), .xa(xa), .ya(ya), .xb(xb), .yb(yb),
            .ex(exa[l]), .ey(eya[l]), .ok_ff(lane_ok[l])
         );
      end else begin : g_box_b
         obb_axis_lane u_lane (
            .clock(clock), .en(en), .xa(xa), .ya(ya), .xb(xb), .yb(yb),
            .ex(exb[l-4]), .ey(eyb[l-4]), .ok_ff(lane_ok[l])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fld_ff[1] <= req_ch.data;
         for (int k = 2; k <= obb_pkg::SINE_LAT; k++) begin
            fld_ff[k] <= fld_ff[k-1];
         end
         collided_ff <= &lane_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= obb_pkg::PIPE_LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[1] <= req_ch.valid;
         for (int k = 2; k <= obb_pkg::PIPE_LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rsp_valid_ff <= valid_ff[obb_pkg::PIPE_LAT];
      end
   end

endmodule

`default_nettype wire
